[sv/tcw_pkg.sv]
// Shared constants and field widths of the text console writer.
package tcw_pkg;

  localparam int SCR_COLS = 80;
  localparam int SCR_ROWS = 25;

  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int POS_OUT_W  = 11;

  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

endpackage

[sv/tcw_if.sv]
// Request and result channel interfaces of the text console writer.
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output req_type, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input req_type, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [POS_OUT_W-1:0] cursor_pos;
  logic                 scrolled;
  logic [CELL_W-1:0]    cell_word;

  modport source (output valid, output cursor_col, output cursor_row, output cursor_pos,
                  output scrolled, output cell_word, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input cursor_pos,
                  input scrolled, input cell_word, output ready);
endinterface

[sv/tcw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/text_console_writer_top.sv]
// Top level of the text console writer: cursor control, screen store and result register.
//
//   channel   dir  handshake          payload
//   in_if     in   valid/ready        req_type, char_code, cell_index
//   out_if    out  valid/ready        cursor_col, cursor_row, cursor_pos, scrolled, cell_word
//   cfg_*     in   cfg_we             cfg_wdata (text attribute)
//
// A put without scroll and an unused code finish in the idle state; a read adds one RAM read.
// A scroll copies the store one cell a cycle through the RAM's single write port and then
// blanks the bottom row. A clear blanks every cell. After reset the store is zeroed by a
// pass over all SCREEN_COLS*SCREEN_ROWS cells (2000 by default), during which no request
// is taken. A finished result waits in a holding register, so one request is taken while
// the output register is stalled.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int SCREEN_COLS = SCR_COLS,
  parameter int SCREEN_ROWS = SCR_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_if,
  tcw_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  // One bit above both widths so that the cell count itself is representable.
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_START = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [POS_OUT_W-1:0] cursor_pos;
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_word;
  } result_t;

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                wb_valid_r, wb_valid_nxt;
  logic [ADDR_W-1:0]   wb_addr_r, wb_addr_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                res_pend_r, res_pend_nxt;
  result_t             res_r, res_nxt;
  logic                out_valid_r;
  result_t             out_r;
  logic [ATTR_W-1:0]   attr_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                out_free;
  logic                in_xfer;
  logic [CELL_W-1:0]   blank_cell;
  logic [CMP_W-1:0]    cidx_ext;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign blank_cell   = {attr_r, CH_SPACE};
  assign cidx_ext     = CMP_W'(in_if.cell_index);
  assign out_free     = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE) && (!res_pend_r || out_free);
  assign in_xfer      = in_if.ready && in_if.valid;

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    wb_valid_nxt = 1'b0;
    wb_addr_nxt  = wb_addr_r;
    rd_ok_nxt    = rd_ok_r;
    res_nxt      = res_r;
    res_pend_nxt = res_pend_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = blank_cell;
    ram_raddr    = cnt_r;

    // The held result moves to the output register in this cycle.
    if (res_pend_r && out_free) begin
      res_pend_nxt = 1'b0;
    end

    // Write-back of a cell copied one row up during a scroll.
    if (wb_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_r;
      ram_wdata = ram_rdata;
    end

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          res_nxt.scrolled  = 1'b0;
          res_nxt.cell_word = '0;
          case (in_if.req_type)
            REQ_PUT: begin
              if (in_if.char_code == CH_NEWLINE) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  res_nxt.scrolled = 1'b1;
                end else begin
                  row_nxt      = row_r + 1'b1;
                  pos_nxt      = pos_r - ADDR_W'(col_r) + COLS_A;
                  res_pend_nxt = 1'b1;
                end
              end else if (in_if.char_code == CH_BACKSPACE) begin
                if (col_r != '0) begin
                  col_nxt   = col_r - 1'b1;
                  pos_nxt   = pos_r - 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = pos_r - 1'b1;
                  ram_wdata = blank_cell;
                end
                res_pend_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_r;
                ram_wdata = {attr_r, in_if.char_code};
                if (col_r == LAST_COL) begin
                  col_nxt = '0;
                  if (row_r == LAST_ROW) begin
                    res_nxt.scrolled = 1'b1;
                  end else begin
                    row_nxt      = row_r + 1'b1;
                    pos_nxt      = pos_r + 1'b1;
                    res_pend_nxt = 1'b1;
                  end
                end else begin
                  col_nxt      = col_r + 1'b1;
                  pos_nxt      = pos_r + 1'b1;
                  res_pend_nxt = 1'b1;
                end
              end
              if (res_nxt.scrolled) begin
                // The cursor lands at the start of the bottom row; the copy starts
                // by reading the first cell of the second row.
                row_nxt   = LAST_ROW;
                pos_nxt   = LAST_START;
                cnt_nxt   = COLS_A;
                state_nxt = ST_SCROLL;
              end
            end
            REQ_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              pos_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            REQ_READ: begin
              ram_raddr = cidx_ext[ADDR_W-1:0];
              rd_ok_nxt = cidx_ext < CMP_W'(CELLS);
              state_nxt = ST_READ;
            end
            default: begin
              res_pend_nxt = 1'b1;
            end
          endcase
          res_nxt.cursor_col = COL_OUT_W'(col_nxt);
          res_nxt.cursor_row = ROW_OUT_W'(row_nxt);
          res_nxt.cursor_pos = POS_OUT_W'(pos_nxt);
        end
      end

      ST_READ: begin
        res_nxt.cell_word = rd_ok_r ? ram_rdata : '0;
        res_pend_nxt      = 1'b1;
        state_nxt         = ST_IDLE;
      end

      ST_SCROLL: begin
        ram_raddr    = cnt_r;
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = cnt_r - COLS_A;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = LAST_START;
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_BLANK: begin
        // The last copied cell still owns the write port in the first cycle here.
        if (!wb_valid_r) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r;
          ram_wdata = blank_cell;
          if (cnt_r == LAST_CELL) begin
            cnt_nxt      = '0;
            res_pend_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = blank_cell;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt      = '0;
          res_pend_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      wb_valid_r  <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_RESET;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pos_r      <= pos_nxt;
      cnt_r      <= cnt_nxt;
      wb_valid_r <= wb_valid_nxt;
      res_pend_r <= res_pend_nxt;
      if (res_pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= wb_addr_nxt;
    rd_ok_r   <= rd_ok_nxt;
    res_r     <= res_nxt;
    if (res_pend_r && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.cursor_col = out_r.cursor_col;
  assign out_if.cursor_row = out_r.cursor_row;
  assign out_if.cursor_pos = out_r.cursor_pos;
  assign out_if.scrolled   = out_r.scrolled;
  assign out_if.cell_word  = out_r.cell_word;

endmodule

[bench/tb_top.sv]
// Self-checking testbench of the text console writer: directed and random requests.
module tb_top import tcw_pkg::*; ();

  localparam int CELLS = SCR_COLS * SCR_ROWS;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] pos;
    logic                 scrolled;
    logic [CELL_W-1:0]    word;
  } cursor_result_t;

  // Shadow copy of the screen store and cursor, with the results still due.
  class console_shadow;
    logic [CELL_W-1:0] cells [CELLS];
    int                col;
    int                row;
    logic [ATTR_W-1:0] attr;
    cursor_result_t    due_results [$];
    int                fail_count;
    int                checked_count;
    int                scroll_count;

    function new();
      foreach (cells[i]) cells[i] = '0;
      col = 0;
      row = 0;
      attr = ATTR_RESET;
      fail_count = 0;
      checked_count = 0;
      scroll_count = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                               logic [IDX_W-1:0] idx);
      cursor_result_t exp;
      exp = '0;
      case (req)
        REQ_PUT: begin
          if (ch == CH_NEWLINE) begin
            col = 0;
            row++;
          end else if (ch == CH_BACKSPACE) begin
            if (col > 0) begin
              col--;
              cells[row * SCR_COLS + col] = {attr, CH_SPACE};
            end
          end else begin
            cells[row * SCR_COLS + col] = {attr, ch};
            col++;
            if (col >= SCR_COLS) begin
              col = 0;
              row++;
            end
          end
          // Passing the last row shifts every row up and blanks the bottom one.
          if (row >= SCR_ROWS) begin
            for (int i = 0; i < CELLS - SCR_COLS; i++) cells[i] = cells[i + SCR_COLS];
            for (int i = CELLS - SCR_COLS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
            row = SCR_ROWS - 1;
            exp.scrolled = 1'b1;
            scroll_count++;
          end
        end
        REQ_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, CH_SPACE};
          col = 0;
          row = 0;
        end
        REQ_READ: begin
          if (idx < CELLS) exp.word = cells[idx];
        end
        default: ;
      endcase
      exp.col = COL_OUT_W'(col);
      exp.row = ROW_OUT_W'(row);
      exp.pos = POS_OUT_W'(row * SCR_COLS + col);
      due_results.push_back(exp);
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(cursor_result_t got);
      cursor_result_t exp;
      checked_count++;
      if (due_results.size() == 0) begin
        note_failure($sformatf(
          "unexpected result: col %0d row %0d pos %0d scrolled %0d cell %h",
          got.col, got.row, got.pos, got.scrolled, got.word));
      end else begin
        exp = due_results.pop_front();
        if (got.col !== exp.col || got.row !== exp.row || got.pos !== exp.pos ||
            got.scrolled !== exp.scrolled || got.word !== exp.word) begin
          note_failure($sformatf({"mismatch: expected col %0d row %0d pos %0d ",
                                  "scrolled %0d cell %h, got col %0d row %0d pos %0d ",
                                  "scrolled %0d cell %h"},
            exp.col, exp.row, exp.pos, exp.scrolled, exp.word,
            got.col, got.row, got.pos, got.scrolled, got.word));
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  req_if ();
  tcw_out_if res_if ();

  text_console_writer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_if),
    .out_if    (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  console_shadow shadow;
  int            src_idle_pct;
  int            snk_stall_pct;
  int            n_put;
  int            n_clear;
  int            n_read;
  int            n_unused;
  int            n_attr;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, one decision per falling edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      shadow.check_result('{res_if.cursor_col, res_if.cursor_row, res_if.cursor_pos,
                            res_if.scrolled, res_if.cell_word});
    end
  end

  // Starts and ends at a falling edge; valid stays high if the next request follows.
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                          input logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= req;
    req_if.char_code  <= ch;
    req_if.cell_index <= idx;
    do @(posedge clk); while (!req_if.ready);
    shadow.note_request(req, ch, idx);
    case (req)
      REQ_PUT:   n_put++;
      REQ_CLEAR: n_clear++;
      REQ_READ:  n_read++;
      default:   n_unused++;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.set_attr(value);
    n_attr++;
    @(negedge clk);
  endtask

  // Bursts of text lines, runs of newlines that drive the cursor into scrolling, reads near
  // the cursor, the bottom rows and past the store, and occasional clears and unused codes.
  task automatic run_random_phase(input int target);
    int   done;
    int   kind;
    int   n;
    int   r;
    int   pos;
    logic [IDX_W-1:0] idx;
    done = 0;
    while (done < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(1, 90);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8)       send_req(REQ_PUT, CH_BACKSPACE, IDX_W'($urandom()));
          else if (r < 12) send_req(REQ_PUT, CH_NEWLINE, IDX_W'($urandom()));
          else             send_req(REQ_PUT, CHAR_W'($urandom_range(0, 255)),
                                    IDX_W'($urandom()));
        end
        done += n;
      end else if (kind < 65) begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) send_req(REQ_PUT, CH_NEWLINE, IDX_W'($urandom()));
        done += n;
      end else if (kind < 88) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            pos = shadow.row * SCR_COLS + shadow.col - $urandom_range(0, 100);
            idx = IDX_W'(pos < 0 ? 0 : pos);
          end else if (r < 60) begin
            idx = IDX_W'($urandom_range(CELLS - 2 * SCR_COLS, CELLS - 1));
          end else if (r < 85) begin
            idx = IDX_W'($urandom_range(0, CELLS - 1));
          end else begin
            idx = IDX_W'($urandom_range(CELLS, 2 ** IDX_W - 1));
          end
          send_req(REQ_READ, CHAR_W'($urandom()), idx);
        end
        done += n;
      end else if (kind < 93) begin
        send_req(REQ_CLEAR, CHAR_W'($urandom()), IDX_W'($urandom()));
        done++;
      end else begin
        // The unused request code is ignored and does not count toward the target.
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          send_req(REQ_UNUSED, CHAR_W'($urandom()), IDX_W'($urandom()));
        end
      end
    end
  endtask

  initial begin
    shadow = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.char_code = '0;
    req_if.cell_index = '0;
    src_idle_pct = 30;
    snk_stall_pct = 47;
    n_put = 0;
    n_clear = 0;
    n_read = 0;
    n_unused = 0;
    n_attr = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The store reads as zero after reset, including its last cell.
    send_req(REQ_READ, 8'h00, 11'd0);
    send_req(REQ_READ, 8'hFF, IDX_W'(CELLS - 1));
    send_req(REQ_READ, 8'h00, 11'h7FF);
    send_req(REQ_UNUSED, 8'hFF, 11'h7FF);
    // Backspace at column zero leaves everything alone.
    send_req(REQ_PUT, CH_BACKSPACE, 11'd0);
    send_req(REQ_PUT, 8'h00, 11'd0);
    send_req(REQ_PUT, 8'hFF, 11'h7FF);
    send_req(REQ_PUT, 8'h41, 11'd0);
    send_req(REQ_PUT, CH_BACKSPACE, 11'd0);
    send_req(REQ_READ, 8'h00, 11'd2);
    send_req(REQ_READ, 8'h00, 11'd1);
    send_req(REQ_PUT, CH_NEWLINE, 11'd0);
    send_req(REQ_PUT, 8'h7E, 11'd0);
    wait_idle();
    // A new attribute applies only to cells written afterwards.
    write_attr(8'h5A);
    send_req(REQ_PUT, 8'h42, 11'd0);
    send_req(REQ_READ, 8'h00, IDX_W'(SCR_COLS));
    send_req(REQ_READ, 8'h00, IDX_W'(SCR_COLS + 1));
    send_req(REQ_CLEAR, 8'hA5, 11'h555);
    send_req(REQ_READ, 8'h00, 11'd0);
    send_req(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
    send_req(REQ_READ, 8'h00, IDX_W'(CELLS));

    wait_idle();
    write_attr(8'hFF);
    run_random_phase(185);

    wait_idle();
    src_idle_pct = 47;
    snk_stall_pct = 30;
    write_attr(8'h00);
    run_random_phase(185);

    wait_idle();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    write_attr(ATTR_W'($urandom_range(1, 254)));
    run_random_phase(185);

    wait_idle();
    repeat (20) @(negedge clk);
    if (shadow.due_results.size() != 0)
      shadow.note_failure($sformatf("%0d results never arrived", shadow.due_results.size()));
    $display("Covered %0d puts, %0d clears, %0d reads and %0d unused codes under %0d attributes.",
             n_put, n_clear, n_read, n_unused, n_attr + 1);
    $display("Checked %0d results, %0d of them after a scroll; %0d failures.",
             shadow.checked_count, shadow.scroll_count, shadow.fail_count);
    if (shadow.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/tcw_ram.sv
sv/text_console_writer_top.sv
bench/tb_top.sv
